FILE: rtl/qdp_pkg.sv
// ----------------------------------------------------------------------------
// qdp_pkg
// Shared types, constants and helpers of the quantized dot product pair block.
// ----------------------------------------------------------------------------
package qdp_pkg;

    // Width of one pair's partial sum: two 4-bit unsigned by 8-bit signed products.
    localparam int PART_W  = 13;
    localparam int BN_W    = 32;
    localparam int MULT_W  = 16;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NIB_W   = 4;
    localparam int WIDE_W  = 64;
    // Requantization operand: signed 32-bit scale or unsigned 16-bit multiplier.
    localparam int MOP_W   = 33;

    localparam logic [NIB_W-1:0] NIB_MAX = 4'hf;

    localparam logic [CFG_IDX_W-1:0] CFG_BN_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT    = 2'd3;

    typedef struct packed {
        logic                bn_en;
        logic                relu_en;
        logic [SHIFT_W-1:0]  right_shift;
        logic [MULT_W-1:0]   scale_multiplier;
    } t_cfg;

    typedef struct packed {
        logic                     last;
        logic signed [PART_W-1:0] part_a;
        logic signed [PART_W-1:0] part_b;
        logic signed [BN_W-1:0]   scale_a;
        logic signed [BN_W-1:0]   scale_b;
        logic signed [BN_W-1:0]   offset_a;
        logic signed [BN_W-1:0]   offset_b;
    } t_entry;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_back_state;

    function automatic logic [NIB_W-1:0] nib_clip(input logic signed [WIDE_W-1:0] v);
        logic [NIB_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > WIDE_W'(NIB_MAX)) begin
            res = NIB_MAX;
        end else begin
            res = v[NIB_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/qdp_in_if.sv
// ----------------------------------------------------------------------------
// qdp_in_if
// Input channel: one activation pair with the weights of both neurons.
// ----------------------------------------------------------------------------
interface qdp_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         activation_pair;
    logic signed [7:0]  weight_a_first;
    logic signed [7:0]  weight_a_second;
    logic signed [7:0]  weight_b_first;
    logic signed [7:0]  weight_b_second;
    logic signed [31:0] bn_scale_a;
    logic signed [31:0] bn_scale_b;
    logic signed [31:0] bn_offset_a;
    logic signed [31:0] bn_offset_b;
    logic               last_pair;

    modport source (
        output valid, activation_pair, weight_a_first, weight_a_second,
               weight_b_first, weight_b_second, bn_scale_a, bn_scale_b,
               bn_offset_a, bn_offset_b, last_pair,
        input  ready
    );

    modport sink (
        input  valid, activation_pair, weight_a_first, weight_a_second,
               weight_b_first, weight_b_second, bn_scale_a, bn_scale_b,
               bn_offset_a, bn_offset_b, last_pair,
        output ready
    );
endinterface

FILE: rtl/qdp_out_if.sv
// ----------------------------------------------------------------------------
// qdp_out_if
// Result channel: two packed 4-bit neuron values.
// ----------------------------------------------------------------------------
interface qdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_result;

    modport source (output valid, packed_result, input ready);
    modport sink   (input valid, packed_result, output ready);
endinterface

FILE: rtl/qdp_front.sv
// ----------------------------------------------------------------------------
// qdp_front
// Accepts input transfers, forms the per-neuron partial sums of the pair and
// hands a queue entry to the back part.
// ----------------------------------------------------------------------------
module qdp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qdp_in_if.sink         i_in,
    output logic           o_push_valid,
    output qdp_pkg::t_entry o_push_entry,
    input  logic           i_push_ready
);

    logic            r_valid;
    qdp_pkg::t_entry r_entry;
    qdp_pkg::t_entry n_entry;
    logic            take;

    logic [3:0] act_lo;
    logic [3:0] act_hi;
    logic signed [qdp_pkg::PART_W-1:0] pa0, pa1, pb0, pb1;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign take         = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

    always_comb begin
        act_lo = i_in.activation_pair[3:0];
        act_hi = i_in.activation_pair[7:4];
        pa0 = qdp_pkg::PART_W'($signed({1'b0, act_lo}))
              * qdp_pkg::PART_W'(i_in.weight_a_first);
        pa1 = qdp_pkg::PART_W'($signed({1'b0, act_hi}))
              * qdp_pkg::PART_W'(i_in.weight_a_second);
        pb0 = qdp_pkg::PART_W'($signed({1'b0, act_lo}))
              * qdp_pkg::PART_W'(i_in.weight_b_first);
        pb1 = qdp_pkg::PART_W'($signed({1'b0, act_hi}))
              * qdp_pkg::PART_W'(i_in.weight_b_second);
        n_entry.last     = i_in.last_pair;
        n_entry.part_a   = pa0 + pa1;
        n_entry.part_b   = pb0 + pb1;
        n_entry.scale_a  = i_in.bn_scale_a;
        n_entry.scale_b  = i_in.bn_scale_b;
        n_entry.offset_a = i_in.bn_offset_a;
        n_entry.offset_b = i_in.bn_offset_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry <= n_entry;
        end
    end

endmodule

FILE: rtl/qdp_fifo.sv
// ----------------------------------------------------------------------------
// qdp_fifo
// Short register queue of entries between the front and the back part.
// ----------------------------------------------------------------------------
module qdp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  qdp_pkg::t_entry i_push_entry,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output qdp_pkg::t_entry o_pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qdp_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count exceeds depth");

endmodule

FILE: rtl/qdp_back.sv
// ----------------------------------------------------------------------------
// qdp_back
// Accumulates partial sums and requantizes both neurons at the end of a vector.
// ----------------------------------------------------------------------------
module qdp_back #(
    parameter int ACC_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qdp_pkg::t_cfg   i_cfg,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  qdp_pkg::t_entry i_pop_entry,
    qdp_out_if.source       o_res
);

    // Product of the sum with one 17-bit half of the operand.
    localparam int PW = ACC_WIDTH + 17;
    localparam int W  = qdp_pkg::WIDE_W;
    localparam int MW = qdp_pkg::MOP_W;

    qdp_pkg::t_back_state r_state, n_state;

    logic signed [ACC_WIDTH-1:0] r_acc_a, r_acc_b;
    logic signed [ACC_WIDTH-1:0] r_sum_a, r_sum_b;
    logic signed [ACC_WIDTH-1:0] sum_a, sum_b;
    logic signed [MW-1:0]        r_m_a, r_m_b, r_l_a, r_l_b;
    logic signed [MW-1:0]        m_a, m_b, l_a, l_b;
    logic signed [PW-1:0]        r_plo_a, r_plo_b, r_phi_a, r_phi_b;
    logic signed [PW-1:0]        plo_a, plo_b, phi_a, phi_b;
    logic signed [W-1:0]         r_t_a, r_t_b;
    logic signed [W-1:0]         sh_a, sh_b;
    logic                        r_out_valid;
    logic [7:0]                  r_out_data;
    logic                        pop, out_load, bn_mode;

    assign pop     = i_pop_valid && o_pop_ready;
    assign bn_mode = i_cfg.bn_en && i_cfg.relu_en;

    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            qdp_pkg::ST_ACC: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid && i_pop_entry.last) begin
                    n_state = qdp_pkg::ST_MUL;
                end
            end
            qdp_pkg::ST_MUL: begin
                n_state = qdp_pkg::ST_ADD;
            end
            qdp_pkg::ST_ADD: begin
                n_state = qdp_pkg::ST_OUT;
            end
            qdp_pkg::ST_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = qdp_pkg::ST_ACC;
                end
            end
            default: begin
                n_state = qdp_pkg::ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qdp_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        sum_a = r_acc_a + ACC_WIDTH'(i_pop_entry.part_a);
        sum_b = r_acc_b + ACC_WIDTH'(i_pop_entry.part_b);
        // Plain mode multiplies by one; relu-only uses the unsigned multiplier.
        if (bn_mode) begin
            m_a = MW'(i_pop_entry.scale_a);
            m_b = MW'(i_pop_entry.scale_b);
            l_a = MW'(i_pop_entry.offset_a);
            l_b = MW'(i_pop_entry.offset_b);
        end else if (i_cfg.relu_en) begin
            m_a = $signed({{(MW - qdp_pkg::MULT_W){1'b0}}, i_cfg.scale_multiplier});
            m_b = m_a;
            l_a = '0;
            l_b = '0;
        end else begin
            m_a = MW'(1);
            m_b = MW'(1);
            l_a = '0;
            l_b = '0;
        end
        plo_a = PW'(r_sum_a) * PW'($signed({1'b0, r_m_a[15:0]}));
        plo_b = PW'(r_sum_b) * PW'($signed({1'b0, r_m_b[15:0]}));
        phi_a = PW'(r_sum_a) * PW'($signed(r_m_a[MW-1:16]));
        phi_b = PW'(r_sum_b) * PW'($signed(r_m_b[MW-1:16]));
        sh_a  = r_t_a >>> i_cfg.right_shift;
        sh_b  = r_t_b >>> i_cfg.right_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (pop) begin
            if (i_pop_entry.last) begin
                r_acc_a <= '0;
                r_acc_b <= '0;
            end else begin
                r_acc_a <= sum_a;
                r_acc_b <= sum_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_entry.last) begin
            r_sum_a <= sum_a;
            r_sum_b <= sum_b;
            r_m_a   <= m_a;
            r_m_b   <= m_b;
            r_l_a   <= l_a;
            r_l_b   <= l_b;
        end
        if (r_state == qdp_pkg::ST_MUL) begin
            r_plo_a <= plo_a;
            r_plo_b <= plo_b;
            r_phi_a <= phi_a;
            r_phi_b <= phi_b;
        end
        // The 64-bit sum wraps exactly as the requantization arithmetic does.
        if (r_state == qdp_pkg::ST_ADD) begin
            r_t_a <= W'(r_plo_a) + (W'(r_phi_a) <<< 16) + W'(r_l_a);
            r_t_b <= W'(r_plo_b) + (W'(r_phi_b) <<< 16) + W'(r_l_b);
        end
        if (out_load) begin
            r_out_data <= {qdp_pkg::nib_clip(sh_b), qdp_pkg::nib_clip(sh_a)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.packed_result = r_out_data;

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != qdp_pkg::ST_ACC |-> !pop)
        else $error("entry taken while requantizing");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_pop_entry.last |=> r_acc_a == '0 && r_acc_b == '0
                                    && r_state == qdp_pkg::ST_MUL)
        else $error("accumulators not cleared after last pair");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == qdp_pkg::ST_OUT)
        else $error("result loaded outside the output step");

endmodule

FILE: rtl/quantized_dot_product_pair.sv
// ----------------------------------------------------------------------------
// quantized_dot_product_pair
// Two neurons of a quantized fully connected layer: 4-bit activations,
// 8-bit weights, requantized 4-bit results packed into one byte.
// ----------------------------------------------------------------------------
// Throughput: one activation pair per cycle while accumulating; a pair marked
//   last holds the accumulate stage (multiply, add, shift and clip, output
//   load), and a result not yet taken at o_res stalls the output load.
// Path: the front register, the queue, then the three requantization steps.
// Reset: synchronous and active low; clears the accumulators, the queue, the
//   output register and the configuration registers to their defaults.
module quantized_dot_product_pair #(
    parameter int ACC_WIDTH   = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qdp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    qdp_in_if.sink                             i_in,
    qdp_out_if.source                          o_res
);

    qdp_pkg::t_cfg   r_cfg;
    logic            push_valid, push_ready, pop_valid, pop_ready;
    qdp_pkg::t_entry push_entry, pop_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bn_en            <= 1'b0;
            r_cfg.relu_en          <= 1'b0;
            r_cfg.right_shift      <= '0;
            r_cfg.scale_multiplier <= qdp_pkg::MULT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qdp_pkg::CFG_BN_EN:   r_cfg.bn_en   <= i_cfg_data[0];
                qdp_pkg::CFG_RELU_EN: r_cfg.relu_en <= i_cfg_data[0];
                qdp_pkg::CFG_SHIFT:
                    r_cfg.right_shift <= i_cfg_data[qdp_pkg::SHIFT_W-1:0];
                qdp_pkg::CFG_MULT:
                    r_cfg.scale_multiplier <= i_cfg_data[qdp_pkg::MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    qdp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    qdp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    qdp_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_res       (o_res)
    );

endmodule
